// File: sv/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants for the quoted token splitter
// Character codes, payload structs and the lexer-to-queue bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

    // character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_HASH      = 8'h23;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    // result queue geometry
    localparam int RQ_DEPTH  = 4;
    localparam int RQ_AW     = $clog2(RQ_DEPTH);
    localparam int RQ_CW     = $clog2(RQ_DEPTH + 1);
    localparam int MAX_RES   = 2;
    localparam int RES_CW    = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_char;
        logic       token_end;
        logic       is_comment;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic in_quotes;
        logic token_open;
        logic held_backslash;
        logic in_comment;
    } t_lex_state;

    // results of one byte, handed to the result queue
    typedef struct packed {
        logic                    push;
        logic [RES_CW-1:0]       count;
        t_out_item [MAX_RES-1:0] item;
    } t_lex_out;

endpackage

`default_nettype wire

// File: sv/qts_lexer.sv
// ----------------------------------------------------------------------------
// qts_lexer: per-byte tokeniser step
// Holds the quote/token/backslash/comment flags and turns one byte into
// up to two result items.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_lexer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire qts_pkg::t_in_item i_item,
    output qts_pkg::t_lex_out      o_res
);

    qts_pkg::t_lex_state r_state;
    qts_pkg::t_lex_state n_state;

    function automatic qts_pkg::t_out_item mk_item(
        input logic [7:0] byte_v,
        input logic       has_v,
        input logic       end_v,
        input logic       com_v
    );
        qts_pkg::t_out_item it;
        it.out_byte    = has_v ? byte_v : 8'h00;
        it.has_char    = has_v;
        it.token_end   = end_v;
        it.is_comment  = com_v;
        it.last_result = 1'b0;
        return it;
    endfunction

    always_comb begin
        logic [7:0]                    b;
        logic                          le;
        logic                          blank;
        logic                          normal;
        logic [qts_pkg::RES_CW-1:0]    n;
        qts_pkg::t_out_item [qts_pkg::MAX_RES-1:0] res;
        qts_pkg::t_out_item            close_it;

        b        = i_item.in_byte;
        le       = i_item.line_end;
        blank    = (b == qts_pkg::CHAR_SPACE) ||
                   ((b >= qts_pkg::CHAR_TAB) && (b <= qts_pkg::CHAR_CR));
        normal   = 1'b1;
        n        = '0;
        res      = '0;
        close_it = mk_item(8'h00, 1'b0, 1'b1, 1'b0);
        n_state  = r_state;

        if (r_state.in_comment) begin
            res[0] = mk_item(b, 1'b1, le, 1'b1);
            n      = 2'd1;
            if (le) begin
                n_state = '0;
            end
        end else begin
            if (r_state.held_backslash) begin
                n_state.held_backslash = 1'b0;
                n_state.token_open     = 1'b1;
                if (b == qts_pkg::CHAR_QUOTE) begin
                    res[0] = mk_item(qts_pkg::CHAR_QUOTE, 1'b1, 1'b0, 1'b0);
                    normal = 1'b0;
                end else begin
                    res[0] = mk_item(qts_pkg::CHAR_BACKSLASH, 1'b1, 1'b0, 1'b0);
                end
                n = 2'd1;
            end
            if (normal) begin
                if (!r_state.in_quotes && blank) begin
                    if (n_state.token_open) begin
                        if (n != 2'd2) begin
                            res[n[0]] = close_it;
                            n = n + 2'd1;
                        end
                        n_state.token_open = 1'b0;
                    end
                end else if (b == qts_pkg::CHAR_BACKSLASH && r_state.in_quotes && !le) begin
                    n_state.held_backslash = 1'b1;
                end else if (b == qts_pkg::CHAR_HASH && !r_state.in_quotes) begin
                    if (n_state.token_open) begin
                        if (n != 2'd2) begin
                            res[n[0]] = close_it;
                            n = n + 2'd1;
                        end
                        n_state.token_open = 1'b0;
                    end
                    if (!le) begin
                        if (n != 2'd2) begin
                            res[n[0]] = mk_item(qts_pkg::CHAR_HASH, 1'b1, 1'b0, 1'b1);
                            n = n + 2'd1;
                        end
                        n_state.in_comment = 1'b1;
                    end
                end else if (b == qts_pkg::CHAR_QUOTE) begin
                    n_state.in_quotes = !r_state.in_quotes;
                end else begin
                    if (n != 2'd2) begin
                        res[n[0]] = mk_item(b, 1'b1, 1'b0, 1'b0);
                        n = n + 2'd1;
                    end
                    n_state.token_open = 1'b1;
                end
            end
            if (le) begin
                if (n_state.token_open) begin
                    // tag the last character, else add an explicit close
                    if (n != 2'd0 && res[n[1]].has_char) begin
                        res[n[1]].token_end = 1'b1;
                    end else if (n != 2'd2) begin
                        res[n[0]] = close_it;
                        n = n + 2'd1;
                    end
                end
                n_state = '0;
            end
        end

        if (n != 2'd0) begin
            res[n[1]].last_result = 1'b1;
        end

        o_res.push  = i_advance && (n != 2'd0);
        o_res.count = n;
        o_res.item  = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/qts_rq.sv
// ----------------------------------------------------------------------------
// qts_rq: result queue
// Takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_rq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire qts_pkg::t_lex_out  i_res,
    output logic                    o_room,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output qts_pkg::t_out_item      o_out_data
);

    qts_pkg::t_out_item r_mem [qts_pkg::RQ_DEPTH];
    logic [qts_pkg::RQ_AW-1:0] r_wr_ptr;
    logic [qts_pkg::RQ_AW-1:0] r_rd_ptr;
    logic [qts_pkg::RQ_CW-1:0] r_count;
    logic [qts_pkg::RQ_AW-1:0] wr_ptr1;
    logic                      pop;
    logic [qts_pkg::RQ_CW-1:0] push_n;

    assign wr_ptr1     = r_wr_ptr + 1'b1;
    assign pop         = (r_count != '0) && !i_out_stall;
    assign push_n      = i_res.push ? qts_pkg::RQ_CW'(i_res.count) : '0;
    assign o_room      = r_count <= qts_pkg::RQ_CW'(qts_pkg::RQ_DEPTH - qts_pkg::MAX_RES);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_res.push) begin
            r_mem[r_wr_ptr] <= i_res.item[0];
            if (i_res.count == 2'd2) begin
                r_mem[wr_ptr1] <= i_res.item[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + qts_pkg::RQ_AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + push_n - qts_pkg::RQ_CW'(pop);
        end
    end

endmodule

`default_nettype wire

// File: sv/quoted_token_splitter.sv
// ----------------------------------------------------------------------------
// quoted_token_splitter: splits a byte stream line into quoted tokens
// Path: a byte's results pass the input register, then the result queue.
// Throughput: one byte per cycle while the queue has room; two results of a
// byte leave one per transfer via the one-wide port behind a 4-entry queue.
// Reset (synchronous, active low) clears the flags, input register and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_token_splitter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire qts_pkg::t_in_item  i_in_data,
    // result output, one result item per transfer
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output qts_pkg::t_out_item      o_out_data
);

    // Input register: holds the byte being tokenised this cycle.
    logic              r_in_valid;
    qts_pkg::t_in_item r_in_item;

    logic              room;      // queue can take a two-result byte
    logic              advance;   // registered byte is consumed
    qts_pkg::t_lex_out lex_res;

    // The byte moves on only when the queue has room for its worst case,
    // so the lexer never has to hold partial results.
    assign advance    = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
    end

    // Tokeniser step: flags plus up to two results per byte.
    qts_lexer u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_res     (lex_res)
    );

    // Result queue decouples the two-wide result burst from the output port.
    qts_rq u_rq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (lex_res),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
